// ----- hdl/omd_pkg.sv -----
// Shared types and constants for the omni drive wheel mixer.
`default_nettype none

package omd_pkg;

   // Number of wheels and width of the quotient produced by the divider.
   localparam int OMD_LANES = 4;
   localparam int OMD_QUO_W = 7;

   // Wheel lane positions inside a lane bank.
   localparam int LANE_NE = 0;
   localparam int LANE_NW = 1;
   localparam int LANE_SE = 2;
   localparam int LANE_SW = 3;

   localparam logic [6:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [8:0] direction;
      logic [6:0] speed;
      logic [8:0] heading;
   } omd_req_type;

   typedef struct packed {
      logic [6:0] ne_power;
      logic       ne_reverse;
      logic [6:0] nw_power;
      logic       nw_reverse;
      logic [6:0] se_power;
      logic       se_reverse;
      logic [6:0] sw_power;
      logic       sw_reverse;
   } omd_rsp_type;

   // One wheel on its way through the divider.
   typedef struct packed {
      logic [14:0] rem;
      logic [7:0]  div;
      logic [6:0]  quo;
      logic [6:0]  mag;
      logic        scale;
      logic        rev;
   } omd_lane_type;

   typedef omd_lane_type [OMD_LANES-1:0] omd_bank_type;

endpackage

`default_nettype wire

// ----- hdl/omd_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, four wheel lanes.
`default_nettype none

module omd_div_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire omd_pkg::omd_bank_type in_bank,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output omd_pkg::omd_bank_type     out_bank
);
   import omd_pkg::*;

   localparam int STEPS = OMD_QUO_W;

   // One restoring step: try to take the divisor shifted up by the bit weight.
   function automatic omd_lane_type div_step(input omd_lane_type l, input int b);
      logic [14:0]  trial;
      omd_lane_type r;
      trial = 15'(l.div) << b;
      r = l;
      if (l.rem >= trial) begin
         r.rem = l.rem - trial;
         r.quo[b] = 1'b1;
      end
      return r;
   endfunction

   logic [STEPS:0]  adv;
   logic            stage_v_ff [STEPS];
   omd_bank_type    stage_ff [STEPS];

   always_comb begin
      adv[STEPS] = out_ready;
      for (int k = STEPS - 1; k >= 0; k--) begin
         adv[k] = !stage_v_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = stage_v_ff[STEPS-1];
   assign out_bank  = stage_ff[STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      omd_bank_type src;
      logic         src_v;
      omd_bank_type stage_in;

      if (k == 0) begin : g_first
         assign src   = in_bank;
         assign src_v = in_valid;
      end else begin : g_rest
         assign src   = stage_ff[k-1];
         assign src_v = stage_v_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < OMD_LANES; i++) begin
            stage_in[i] = div_step(src[i], STEPS - 1 - k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            stage_v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/omni_drive_wheel_mixer_core.sv -----
// Top level of the four-wheel omni drive mixer.
//
//   Channel | Direction | Handshake            | Beat contents
//   req     | in        | req_valid/req_ready  | direction, speed, heading
//   rsp     | out       | rsp_valid/rsp_ready  | power and reverse flag per wheel
//
// A beat accepted on req passes through five front stages, seven divider
// stages (one quotient bit each) and the output register before it reaches
// rsp. One beat can be accepted every cycle unless rsp stalls all stages.
// Reset is synchronous and clears only the valid bits of every stage.
// A stall on rsp backs up only as far as the first empty stage, so bubbles
// are squeezed out and no beat is lost or repeated.
`default_nettype none

module omni_drive_wheel_mixer_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire omd_pkg::omd_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output omd_pkg::omd_rsp_type      rsp_data
);
   import omd_pkg::*;

   // Reciprocal constants: floor(v*5/9) = (v*36410) >> 16 for v up to 180,
   // and floor(p/100) = (p*5243) >> 19 for p up to 12700.
   localparam logic [15:0] ROT_RECIP = 16'd36410;
   localparam logic [12:0] PCT_RECIP = 13'd5243;

   typedef struct packed {
      logic [8:0] dir;
      logic [8:0] head;
      logic [6:0] spd;
   } st_a_type;

   typedef struct packed {
      logic [6:0] xm;
      logic       xn;
      logic [6:0] ym;
      logic       yn;
      logic [7:0] ang;
      logic       rneg;
      logic [6:0] spd;
   } st_b_type;

   typedef struct packed {
      logic [13:0] px;
      logic        xn;
      logic [13:0] py;
      logic        yn;
      logic [6:0]  rot;
      logic        rneg;
      logic [6:0]  spd;
   } st_c_type;

   typedef struct packed {
      logic [6:0] qx;
      logic       xn;
      logic [6:0] qy;
      logic       yn;
      logic [6:0] rot;
      logic       rneg;
      logic [6:0] spd;
   } st_d_type;

   // Rounded 100*tan(k degrees) for k = 0..45.
   function automatic logic [6:0] tan_lookup(input logic [5:0] k);
      logic [6:0] t;
      case (k)
         6'd0:  t = 7'd0;   6'd1:  t = 7'd2;   6'd2:  t = 7'd3;   6'd3:  t = 7'd5;
         6'd4:  t = 7'd7;   6'd5:  t = 7'd9;   6'd6:  t = 7'd11;  6'd7:  t = 7'd12;
         6'd8:  t = 7'd14;  6'd9:  t = 7'd16;  6'd10: t = 7'd18;  6'd11: t = 7'd19;
         6'd12: t = 7'd21;  6'd13: t = 7'd23;  6'd14: t = 7'd25;  6'd15: t = 7'd27;
         6'd16: t = 7'd29;  6'd17: t = 7'd31;  6'd18: t = 7'd32;  6'd19: t = 7'd34;
         6'd20: t = 7'd36;  6'd21: t = 7'd38;  6'd22: t = 7'd40;  6'd23: t = 7'd42;
         6'd24: t = 7'd45;  6'd25: t = 7'd47;  6'd26: t = 7'd49;  6'd27: t = 7'd51;
         6'd28: t = 7'd53;  6'd29: t = 7'd55;  6'd30: t = 7'd58;  6'd31: t = 7'd60;
         6'd32: t = 7'd62;  6'd33: t = 7'd65;  6'd34: t = 7'd67;  6'd35: t = 7'd70;
         6'd36: t = 7'd73;  6'd37: t = 7'd75;  6'd38: t = 7'd78;  6'd39: t = 7'd81;
         6'd40: t = 7'd84;  6'd41: t = 7'd87;  6'd42: t = 7'd90;  6'd43: t = 7'd93;
         6'd44: t = 7'd97;
         default: t = 7'd100;
      endcase
      return t;
   endfunction

   // Final magnitude: the quotient when scaling applies, clamped to full scale.
   function automatic logic [6:0] final_mag(input omd_lane_type l);
      logic [6:0] m;
      if (!l.scale) begin
         m = l.mag;
      end else if (l.div == 8'd0 || l.quo > PCT_FULL) begin
         m = PCT_FULL;
      end else begin
         m = l.quo;
      end
      return m;
   endfunction

   // Stage valid bits and payloads.
   logic         a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff;
   st_a_type     a_ff, a_in;
   st_b_type     b_ff, b_in;
   st_c_type     c_ff, c_in;
   st_d_type     d_ff, d_in;
   omd_bank_type e_ff, e_in;

   logic         a_adv, b_adv, c_adv, d_adv, e_adv, out_adv;
   logic         div_in_ready, div_out_valid;
   omd_bank_type div_out_bank;

   logic         rsp_valid_ff;
   omd_rsp_type  rsp_data_ff, rsp_data_in;

   // A stage loads whenever it is empty or its successor is taking its beat.
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign e_adv     = !e_v_ff || div_in_ready;
   assign d_adv     = !d_v_ff || e_adv;
   assign c_adv     = !c_v_ff || d_adv;
   assign b_adv     = !b_v_ff || c_adv;
   assign a_adv     = !a_v_ff || b_adv;
   assign req_ready = a_adv;

   // Stage A: fold out-of-range direction and heading back by a full turn.
   always_comb begin
      a_in.dir  = (req_data.direction > 9'd360) ? req_data.direction - 9'd360
                                                 : req_data.direction;
      a_in.head = (req_data.heading >= 9'd360) ? req_data.heading - 9'd360
                                                : req_data.heading;
      a_in.spd  = req_data.speed;
   end

   // Stage B: quadrant decode and tangent lookup give the unit drive vector
   // as magnitude and sign; the heading error becomes an angle of at most 180.
   logic [8:0] b_center;
   logic [8:0] b_diff;
   logic [6:0] b_tan;
   logic [8:0] b_back;

   always_comb begin
      if (a_ff.dir <= 9'd90) begin
         b_center = 9'd45;
      end else if (a_ff.dir <= 9'd180) begin
         b_center = 9'd135;
      end else if (a_ff.dir <= 9'd270) begin
         b_center = 9'd225;
      end else begin
         b_center = 9'd315;
      end
      b_diff = (a_ff.dir >= b_center) ? a_ff.dir - b_center : b_center - a_ff.dir;
      b_tan  = tan_lookup((b_diff > 9'd45) ? 6'd45 : b_diff[5:0]);

      if (a_ff.dir <= 9'd90) begin
         b_in.xm = PCT_FULL;  b_in.xn = 1'b0;
         b_in.ym = b_tan;     b_in.yn = (a_ff.dir > b_center);
      end else if (a_ff.dir <= 9'd180) begin
         b_in.xm = b_tan;     b_in.xn = (a_ff.dir > b_center);
         b_in.ym = PCT_FULL;  b_in.yn = 1'b1;
      end else if (a_ff.dir <= 9'd270) begin
         b_in.xm = PCT_FULL;  b_in.xn = 1'b1;
         b_in.ym = b_tan;     b_in.yn = (a_ff.dir < b_center);
      end else begin
         b_in.xm = b_tan;     b_in.xn = (a_ff.dir < b_center);
         b_in.ym = PCT_FULL;  b_in.yn = 1'b0;
      end

      b_back = 9'd360 - a_ff.head;
      if (a_ff.head > 9'd180) begin
         b_in.ang  = b_back[7:0];
         b_in.rneg = 1'b1;
      end else begin
         b_in.ang  = a_ff.head[7:0];
         b_in.rneg = 1'b0;
      end
      b_in.spd = a_ff.spd;
   end

   // Stage C: scale the vector by speed and form rot = angle*5/9.
   logic [23:0] c_rot_prod;

   always_comb begin
      c_rot_prod = 24'(b_ff.ang) * 24'(ROT_RECIP);
      c_in.px    = 14'(b_ff.xm) * 14'(b_ff.spd);
      c_in.py    = 14'(b_ff.ym) * 14'(b_ff.spd);
      c_in.xn    = b_ff.xn;
      c_in.yn    = b_ff.yn;
      c_in.rot   = c_rot_prod[22:16];
      c_in.rneg  = b_ff.rneg;
      c_in.spd   = b_ff.spd;
   end

   // Stage D: divide the speed products by 100, truncating the magnitude,
   // which matches truncation toward zero once the sign is put back.
   logic [26:0] d_qx_prod, d_qy_prod;

   always_comb begin
      d_qx_prod = 27'(c_ff.px) * 27'(PCT_RECIP);
      d_qy_prod = 27'(c_ff.py) * 27'(PCT_RECIP);
      d_in.qx   = d_qx_prod[25:19];
      d_in.qy   = d_qy_prod[25:19];
      d_in.xn   = c_ff.xn;
      d_in.yn   = c_ff.yn;
      d_in.rot  = c_ff.rot;
      d_in.rneg = c_ff.rneg;
      d_in.spd  = c_ff.spd;
   end

   // Stage E: mix in the heading correction, split sign from magnitude and
   // prepare the divider operands for wheels that exceed full scale.
   logic signed [8:0] e_xb, e_yb, e_reff;
   logic signed [8:0] e_val [OMD_LANES];
   logic [7:0]        e_mag [OMD_LANES];

   always_comb begin
      e_xb   = d_ff.xn   ? -$signed({2'b00, d_ff.qx})  : $signed({2'b00, d_ff.qx});
      e_yb   = d_ff.yn   ? -$signed({2'b00, d_ff.qy})  : $signed({2'b00, d_ff.qy});
      e_reff = d_ff.rneg ? -$signed({2'b00, d_ff.rot}) : $signed({2'b00, d_ff.rot});

      e_val[LANE_NE] = e_yb + e_reff;
      e_val[LANE_NW] = e_xb - e_reff;
      e_val[LANE_SE] = e_xb + e_reff;
      e_val[LANE_SW] = e_yb - e_reff;

      for (int i = 0; i < OMD_LANES; i++) begin
         e_mag[i]       = e_val[i][8] ? 8'(-e_val[i]) : e_val[i][7:0];
         e_in[i].rem    = 15'(e_mag[i]) * 15'(PCT_FULL);
         e_in[i].div    = 8'(d_ff.spd) + 8'(d_ff.rot);
         e_in[i].quo    = '0;
         e_in[i].mag    = e_mag[i][6:0];
         e_in[i].scale  = (e_mag[i] > 8'(PCT_FULL));
         e_in[i].rev    = e_val[i][8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         if (a_adv) a_v_ff <= req_valid;
         if (b_adv) b_v_ff <= a_v_ff;
         if (c_adv) c_v_ff <= b_v_ff;
         if (d_adv) d_v_ff <= c_v_ff;
         if (e_adv) e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) a_ff <= a_in;
      if (b_adv) b_ff <= b_in;
      if (c_adv) c_ff <= c_in;
      if (d_adv) d_ff <= d_in;
      if (e_adv) e_ff <= e_in;
   end

   // Scaling divide mag*100/(speed+rot), one quotient bit per stage.
   omd_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_v_ff),
      .in_ready  (div_in_ready),
      .in_bank   (e_ff),
      .out_valid (div_out_valid),
      .out_ready (out_adv),
      .out_bank  (div_out_bank)
   );

   // Output register: picks scaled or plain magnitude per wheel.
   always_comb begin
      rsp_data_in.ne_power   = final_mag(div_out_bank[LANE_NE]);
      rsp_data_in.ne_reverse = div_out_bank[LANE_NE].rev;
      rsp_data_in.nw_power   = final_mag(div_out_bank[LANE_NW]);
      rsp_data_in.nw_reverse = div_out_bank[LANE_NW].rev;
      rsp_data_in.se_power   = final_mag(div_out_bank[LANE_SE]);
      rsp_data_in.se_reverse = div_out_bank[LANE_SE].rev;
      rsp_data_in.sw_power   = final_mag(div_out_bank[LANE_SW]);
      rsp_data_in.sw_reverse = div_out_bank[LANE_SW].rev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/omd_checker.sv -----
// Port-level checks for the omni drive mixer, bound to the top level.
`default_nettype none

module omd_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire omd_pkg::omd_rsp_type rsp_data
);
   import omd_pkg::*;

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result beat keeps its contents.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Every wheel magnitude stays within full scale.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ne_power <= PCT_FULL && rsp_data.nw_power <= PCT_FULL &&
                     rsp_data.se_power <= PCT_FULL && rsp_data.sw_power <= PCT_FULL))
      else $error("wheel magnitude above full scale");

   // A wheel at rest is never flagged as reversing.
   a_zero_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.ne_power != 7'd0 || !rsp_data.ne_reverse) &&
                     (rsp_data.nw_power != 7'd0 || !rsp_data.nw_reverse) &&
                     (rsp_data.se_power != 7'd0 || !rsp_data.se_reverse) &&
                     (rsp_data.sw_power != 7'd0 || !rsp_data.sw_reverse)))
      else $error("zero magnitude with reverse flag set");

   // Reset empties the pipeline, so no result follows it directly.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind omni_drive_wheel_mixer_core omd_checker u_omd_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the four-wheel omni drive mixer core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import omd_pkg::*;

   // Receiver behavior while draining results; a new mode is chosen whenever the
   // last one runs out, so that stalls land on every stage of the pipeline.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   // One wheel's drive as the block reports it.
   typedef struct packed {
      logic [6:0] power;
      logic       reverse;
   } wheel_drive_type;

   // round(100*tan(k degrees)) for k = 0..45.
   localparam int TAN_PCT [0:45] = '{
      0, 2, 3, 5, 7, 9, 11, 12, 14, 16,
      18, 19, 21, 23, 25, 27, 29, 31, 32, 34,
      36, 38, 40, 42, 45, 47, 49, 51, 53, 55,
      58, 60, 62, 65, 67, 70, 73, 75, 78, 81,
      84, 87, 90, 93, 97, 100
   };

   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_BEATS  = 1700;
   // Extra cycles to watch for stray beats after the last expected result.
   localparam int DRAIN_CYCLES  = 60;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   omd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   omd_rsp_type rsp_data;

   // Expected wheel drives, oldest first, one per accepted command beat.
   omd_rsp_type   wheel_expect_q[$];
   int            error_count = 0;
   int            burst_left  = 0;
   int            stall_left  = 0;
   int            period_count = 0;
   ready_mode_type stall_mode = READY_ALWAYS;

   omni_drive_wheel_mixer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the slowest legal run needs well under a tenth of this.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Signed tangent in percent for an offset of -45..45 degrees from a diagonal.
   function automatic int tangent_pct(input int angle);
      int mag;
      mag = (angle < 0) ? -angle : angle;
      if (mag > 45) mag = 45;
      return (angle < 0) ? -TAN_PCT[mag] : TAN_PCT[mag];
   endfunction

   // Turns a signed wheel value into magnitude and reverse flag. Magnitudes
   // beyond full scale are brought back by the speed-plus-correction total.
   function automatic wheel_drive_type drive_from_value(input int value, input int divisor);
      wheel_drive_type drive;
      int mag;
      mag = (value < 0) ? -value : value;
      drive.reverse = (value < 0);
      if (mag > 100) begin
         mag = (divisor > 0) ? (mag * 100) / divisor : 100;
         if (mag > 100) mag = 100;
      end
      drive.power = mag[6:0];
      return drive;
   endfunction

   // Computes the four wheel drives for one command.
   function automatic omd_rsp_type predict_wheels(input omd_req_type cmd);
      omd_rsp_type     res;
      wheel_drive_type drive;
      int dir, spd, hdg, vx, vy, rot;
      int ne, nw, se, sw;
      dir = cmd.direction;
      spd = cmd.speed;
      hdg = cmd.heading;
      // Out-of-range angles fold back by one full turn.
      if (dir > 360) dir -= 360;
      if (hdg >= 360) hdg -= 360;
      // Travel vector: one component at full scale, the other a tangent.
      if (dir <= 90) begin
         vx = 100;
         vy = tangent_pct(45 - dir);
      end else if (dir <= 180) begin
         vx = tangent_pct(135 - dir);
         vy = -100;
      end else if (dir <= 270) begin
         vx = -100;
         vy = tangent_pct(dir - 225);
      end else begin
         vx = tangent_pct(dir - 315);
         vy = 100;
      end
      // Diagonal wheel pairs share a component; the division truncates toward zero.
      ne = (vy * spd) / 100;
      sw = ne;
      nw = (vx * spd) / 100;
      se = nw;
      // Heading correction turns the robot back toward zero by the short way.
      if (hdg > 180) begin
         rot = ((360 - hdg) * 5) / 9;
         ne -= rot;
         nw += rot;
         se -= rot;
         sw += rot;
      end else begin
         rot = (hdg * 5) / 9;
         ne += rot;
         nw -= rot;
         se += rot;
         sw -= rot;
      end
      drive = drive_from_value(ne, spd + rot);
      res.ne_power   = drive.power;
      res.ne_reverse = drive.reverse;
      drive = drive_from_value(nw, spd + rot);
      res.nw_power   = drive.power;
      res.nw_reverse = drive.reverse;
      drive = drive_from_value(se, spd + rot);
      res.se_power   = drive.power;
      res.se_reverse = drive.reverse;
      drive = drive_from_value(sw, spd + rot);
      res.sw_power   = drive.power;
      res.sw_reverse = drive.reverse;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [6:0] want,
                                input logic [6:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Sends one command beat. The sender works in bursts: between bursts it
   // drops valid for a random number of cycles, sometimes for none at all,
   // so that some stretches run back to back. Valid stays high with the
   // payload unchanged until the handshake completes.
   task automatic send_command(input int dir, input int spd, input int hdg);
      omd_req_type cmd;
      int gap;
      cmd.direction = 9'(dir);
      cmd.speed     = 7'(spd);
      cmd.heading   = 9'(hdg);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
   endtask

   // Every quadrant boundary and diagonal at full speed with no correction.
   task automatic test_quadrant_boundaries();
      int dirs [12] = '{0, 45, 90, 91, 135, 180, 181, 225, 270, 271, 315, 360};
      foreach (dirs[i])
         send_command(dirs[i], PCT_FULL, 0);
   endtask

   // Fields past their nominal range: directions and headings that wrap by a
   // full turn, and speeds of zero and above full scale.
   task automatic test_out_of_range_fields();
      send_command(361, 60, 0);
      send_command(511, 100, 360);
      send_command(200, 0, 511);
      send_command(45, 127, 0);
      send_command(300, 127, 250);
   endtask

   // Heading correction on both sides of the half turn, including cases
   // where a wheel overshoots full scale and must be scaled back, and a
   // zero wheel value that must come out forward.
   task automatic test_heading_correction();
      send_command(0, 100, 180);
      send_command(0, 100, 181);
      send_command(90, 100, 359);
      send_command(180, 80, 1);
      send_command(0, 100, 90);
      send_command(45, 0, 0);
   endtask

   // Random commands: mostly within the documented ranges, the rest using the
   // full width of every field so that each bit is exercised both ways.
   task automatic test_random_commands(input int count);
      repeat (count) begin
         if ($urandom_range(9) < 8)
            send_command($urandom_range(360), $urandom_range(100), $urandom_range(359));
         else
            send_command($urandom_range(511), $urandom_range(127), $urandom_range(511));
      end
   endtask

   // The receiver picks a stall mode for a random stretch of cycles. One mode
   // never stalls; the others stall on a coin toss, mostly, or periodically.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(3));
         stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      period_count++;
      case (stall_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_COIN:     rsp_ready <= $urandom_range(1);
         READY_SPARSE:   rsp_ready <= ($urandom_range(3) == 0);
         default:        rsp_ready <= ((period_count % 8) < 5);
      endcase
   end

   // Scoreboard. Result beats are checked before new command beats are
   // recorded, so a same-edge pair never depends on process order.
   always @(posedge clock) begin
      omd_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (wheel_expect_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected result beat, expected none, got %h",
                           $time, rsp_data);
            end else begin
               want = wheel_expect_q.pop_front();
               compare_field("ne_power",   want.ne_power,   rsp_data.ne_power);
               compare_field("ne_reverse", want.ne_reverse, rsp_data.ne_reverse);
               compare_field("nw_power",   want.nw_power,   rsp_data.nw_power);
               compare_field("nw_reverse", want.nw_reverse, rsp_data.nw_reverse);
               compare_field("se_power",   want.se_power,   rsp_data.se_power);
               compare_field("se_reverse", want.se_reverse, rsp_data.se_reverse);
               compare_field("sw_power",   want.sw_power,   rsp_data.sw_power);
               compare_field("sw_reverse", want.sw_reverse, rsp_data.sw_reverse);
            end
         end
         if (req_valid && req_ready)
            wheel_expect_q.push_back(predict_wheels(req_data));
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_quadrant_boundaries();
      test_out_of_range_fields();
      test_heading_correction();
      test_random_commands(RANDOM_BEATS);

      // The last beat was just accepted; drop valid at this same edge.
      req_valid <= 1'b0;

      // Wait for every expected result, then watch a while longer for any
      // stray beat the block might still emit.
      while (wheel_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
